>>> rtl/qbt_pkg.sv
// qbt_pkg: shared types, widths and codes for the quadtree tile walker
// no dependencies; compiled first
`timescale 1ns / 1ps

package qbt_pkg;

	localparam int QUEUE_DEPTH_DEF = 1024;
	localparam int MAX_LEVEL_DEF   = 15;

	localparam int CFG_W       = 11;
	localparam int OPC_W       = 1;
	localparam int VRD_W       = 2;
	localparam int STS_W       = 2;
	localparam int LVL_OUT_W   = 4;
	localparam int CRD_OUT_W   = 15;
	localparam int LIMIT_RESET = 1024;

	localparam logic [OPC_W-1:0] OP_START   = 1'b0;
	localparam logic [OPC_W-1:0] OP_VERDICT = 1'b1;

	localparam logic [VRD_W-1:0] VRD_PRUNE = 2'd0;
	localparam logic [VRD_W-1:0] VRD_STOP  = 2'd3;

	typedef enum logic [STS_W-1:0] {
		STS_NODE     = 2'd0,
		STS_DONE     = 2'd1,
		STS_OVERFLOW = 2'd2,
		STS_DEPTH    = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    walk_start;
		logic    set_idle;
		logic    hr_direct;
		logic    rem_start;
		logic    push;
		logic [1:0] child;
		logic    pop_read;
		logic    pop_load;
		logic    emit;
		status_t emit_status;
	} qbt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic lim_zero;
		logic head_ge_lim;
		logic full;
		logic count_zero;
		logic level_max;
		logic rem_done;
		logic active;
		logic out_free;
	} qbt_sts_t;

endpackage

>>> rtl/qbt_if.sv
// qbt_if: word channels of the tile walker (request, result, limit write)
// depends on qbt_pkg
`timescale 1ns / 1ps

interface qbt_req_if;
	logic                      valid;
	logic                      ready;
	logic [qbt_pkg::OPC_W-1:0] opcode;
	logic [qbt_pkg::VRD_W-1:0] verdict;

	modport source (output valid, output opcode, output verdict, input ready);
	modport sink   (input valid, input opcode, input verdict, output ready);
endinterface

interface qbt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [qbt_pkg::STS_W-1:0]     status;
	logic [qbt_pkg::LVL_OUT_W-1:0] node_level;
	logic [qbt_pkg::CRD_OUT_W-1:0] node_x;
	logic [qbt_pkg::CRD_OUT_W-1:0] node_y;

	modport source (output valid, output status, output node_level, output node_x,
		output node_y, input ready);
	modport sink   (input valid, input status, input node_level, input node_x,
		input node_y, output ready);
endinterface

interface qbt_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [qbt_pkg::CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/qbt_rem.sv
// qbt_rem: bit-serial restoring remainder, one dividend bit per cycle
// depends on nothing; used by qbt_datapath
`timescale 1ns / 1ps

module qbt_rem #(
	parameter int NUM_W = 10,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] rem
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] r_q;
	logic [DEN_W:0]   trial;
	logic             take;

	assign trial = {r_q, num_q[NUM_W-1]};
	assign take  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			r_q   <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			r_q   <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = NUM_W'(r_q);

endmodule

>>> rtl/qbt_datapath.sv
// qbt_datapath: queue memory, head/count pointers, current tile, limit, result register
// depends on qbt_pkg and qbt_rem; driven by qbt_ctrl commands
`timescale 1ns / 1ps

module qbt_datapath #(
	parameter int QUEUE_DEPTH = qbt_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_LEVEL   = qbt_pkg::MAX_LEVEL_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qbt_pkg::qbt_cmd_t             cmd,
	output qbt_pkg::qbt_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [qbt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [qbt_pkg::STS_W-1:0]     out_status,
	output logic [qbt_pkg::LVL_OUT_W-1:0] out_level,
	output logic [qbt_pkg::CRD_OUT_W-1:0] out_x,
	output logic [qbt_pkg::CRD_OUT_W-1:0] out_y
);
	import qbt_pkg::*;

	localparam int AW     = $clog2(QUEUE_DEPTH);
	localparam int LIM_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W  = (LIM_W > CFG_W) ? LIM_W : CFG_W;
	localparam int LW     = ($clog2(MAX_LEVEL + 1) > LVL_OUT_W) ? $clog2(MAX_LEVEL + 1)
		: LVL_OUT_W;
	localparam int CW     = (MAX_LEVEL > CRD_OUT_W) ? MAX_LEVEL : CRD_OUT_W;
	localparam int ENT_W  = LW + 2 * CW;
	localparam logic [LIM_W-1:0] LIM_RST = (LIMIT_RESET < QUEUE_DEPTH)
		? LIM_W'(LIMIT_RESET) : LIM_W'(QUEUE_DEPTH);

	logic [ENT_W-1:0] mem [QUEUE_DEPTH];
	logic [ENT_W-1:0] rd_q;

	logic [LIM_W-1:0] lim_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    hr_q;
	logic [LIM_W-1:0] count_q;
	logic             active_q;
	logic [LW-1:0]    cur_lvl_q;
	logic [CW-1:0]    cur_x_q;
	logic [CW-1:0]    cur_y_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [LVL_OUT_W-1:0] out_level_q;
	logic [CRD_OUT_W-1:0] out_x_q;
	logic [CRD_OUT_W-1:0] out_y_q;

	logic [CMP_W-1:0] cfg_ext;
	logic [LIM_W-1:0] lim_new;
	logic [LIM_W:0]   pos_sum;
	logic [LIM_W:0]   pos_fix;
	logic [AW-1:0]    push_addr;
	logic [LIM_W-1:0] hr_inc;
	logic [AW-1:0]    head_next;
	logic [ENT_W-1:0] child_ent;
	logic             rem_done;
	logic [AW-1:0]    rem_val;
	logic             lim_zero;

	assign cfg_ext  = CMP_W'(cfg_data);
	assign lim_new  = (cfg_ext < CMP_W'(QUEUE_DEPTH)) ? LIM_W'(cfg_ext) : LIM_W'(QUEUE_DEPTH);
	assign lim_zero = lim_q == '0;

	// ring position of the next free slot
	assign pos_sum   = {1'b0, LIM_W'(hr_q)} + {1'b0, count_q};
	assign pos_fix   = (pos_sum >= {1'b0, lim_q}) ? pos_sum - {1'b0, lim_q} : pos_sum;
	assign push_addr = AW'(pos_fix);

	assign hr_inc    = LIM_W'(hr_q) + LIM_W'(1);
	assign head_next = (lim_zero || hr_inc == lim_q) ? '0 : AW'(hr_inc);

	assign child_ent = {cur_lvl_q + LW'(1),
		cur_x_q[CW-2:0], cmd.child[0],
		cur_y_q[CW-2:0], cmd.child[1]};

	qbt_rem #(
		.NUM_W(AW),
		.DEN_W(LIM_W)
	) u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.rem_start),
		.num   (head_q),
		.den   (lim_q),
		.done  (rem_done),
		.rem   (rem_val)
	);

	// single-port queue memory
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[push_addr] <= child_ent;
		end else if (cmd.walk_start && !lim_zero) begin
			// root tile passes through entry zero
			mem[AW'(0)] <= '0;
		end else if (cmd.pop_read) begin
			rd_q <= mem[hr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q     <= LIM_RST;
			head_q    <= '0;
			hr_q      <= '0;
			count_q   <= '0;
			active_q  <= 1'b0;
			cur_lvl_q <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
		end else begin
			if (cfg_we) begin
				lim_q <= lim_new;
			end
			if (cmd.walk_start) begin
				head_q   <= (lim_q <= LIM_W'(1)) ? '0 : AW'(1);
				count_q  <= '0;
				active_q <= !lim_zero;
				if (!lim_zero) begin
					cur_lvl_q <= '0;
					cur_x_q   <= '0;
					cur_y_q   <= '0;
				end
			end
			if (cmd.set_idle) begin
				active_q <= 1'b0;
			end
			if (cmd.hr_direct) begin
				hr_q <= lim_zero ? '0 : head_q;
			end else if (rem_done) begin
				hr_q <= rem_val;
			end
			if (cmd.push) begin
				count_q <= count_q + LIM_W'(1);
			end
			if (cmd.pop_load) begin
				count_q   <= count_q - LIM_W'(1);
				head_q    <= head_next;
				cur_lvl_q <= rd_q[ENT_W-1 -: LW];
				cur_x_q   <= rd_q[2*CW-1 -: CW];
				cur_y_q   <= rd_q[CW-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			if (cmd.emit_status == STS_NODE) begin
				out_level_q <= cur_lvl_q[LVL_OUT_W-1:0];
				out_x_q     <= cur_x_q[CRD_OUT_W-1:0];
				out_y_q     <= cur_y_q[CRD_OUT_W-1:0];
			end else begin
				out_level_q <= '0;
				out_x_q     <= '0;
				out_y_q     <= '0;
			end
		end
	end

	assign sts.lim_zero    = lim_zero;
	assign sts.head_ge_lim = LIM_W'(head_q) >= lim_q;
	assign sts.full        = count_q >= lim_q;
	assign sts.count_zero  = count_q == '0;
	assign sts.level_max   = cur_lvl_q >= LW'(MAX_LEVEL);
	assign sts.rem_done    = rem_done;
	assign sts.active      = active_q;
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_level  = out_level_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;

endmodule

>>> rtl/qbt_ctrl.sv
// qbt_ctrl: walk sequencer, one request word at a time
// depends on qbt_pkg; drives qbt_datapath through qbt_cmd_t
`timescale 1ns / 1ps

module qbt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_fire,
	input  logic [qbt_pkg::OPC_W-1:0] opcode,
	input  logic [qbt_pkg::VRD_W-1:0] verdict,
	input  qbt_pkg::qbt_sts_t         sts,
	output qbt_pkg::qbt_cmd_t         cmd,
	output logic                      idle
);
	import qbt_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_PREP   = 7'b0000010,
		S_REDUCE = 7'b0000100,
		S_PUSH   = 7'b0001000,
		S_POPCHK = 7'b0010000,
		S_LOAD   = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	status_t    emit_q, emit_d;
	logic       descend_q, descend_d;
	logic [1:0] child_q, child_d;

	always_comb begin
		state_d         = state_q;
		emit_d          = emit_q;
		descend_d       = descend_q;
		child_d         = child_q;
		cmd             = '0;
		cmd.child       = child_q;
		cmd.emit_status = emit_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					child_d = '0;
					if (opcode == OP_START) begin
						cmd.walk_start = 1'b1;
						emit_d         = sts.lim_zero ? STS_OVERFLOW : STS_NODE;
						state_d        = S_EMIT;
					end else if (!sts.active) begin
						emit_d  = STS_DONE;
						state_d = S_EMIT;
					end else if (verdict == VRD_STOP) begin
						cmd.set_idle = 1'b1;
						emit_d       = STS_DONE;
						state_d      = S_EMIT;
					end else if (verdict != VRD_PRUNE && sts.level_max) begin
						cmd.set_idle = 1'b1;
						emit_d       = STS_DEPTH;
						state_d      = S_EMIT;
					end else begin
						descend_d = verdict != VRD_PRUNE;
						state_d   = S_PREP;
					end
				end
			end
			S_PREP: begin
				if (sts.head_ge_lim && !sts.lim_zero) begin
					cmd.rem_start = 1'b1;
					state_d       = S_REDUCE;
				end else begin
					cmd.hr_direct = 1'b1;
					state_d       = descend_q ? S_PUSH : S_POPCHK;
				end
			end
			S_REDUCE: begin
				if (sts.rem_done) begin
					state_d = descend_q ? S_PUSH : S_POPCHK;
				end
			end
			S_PUSH: begin
				if (sts.full) begin
					cmd.set_idle = 1'b1;
					emit_d       = STS_OVERFLOW;
					state_d      = S_EMIT;
				end else begin
					cmd.push = 1'b1;
					child_d  = child_q + 2'd1;
					if (child_q == 2'd3) begin
						state_d = S_POPCHK;
					end
				end
			end
			S_POPCHK: begin
				if (sts.count_zero) begin
					cmd.set_idle = 1'b1;
					emit_d       = STS_DONE;
					state_d      = S_EMIT;
				end else begin
					cmd.pop_read = 1'b1;
					state_d      = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.pop_load = 1'b1;
				emit_d       = STS_NODE;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			emit_q    <= STS_NODE;
			descend_q <= 1'b0;
			child_q   <= '0;
		end else begin
			state_q   <= state_d;
			emit_q    <= emit_d;
			descend_q <= descend_d;
			child_q   <= child_d;
		end
	end

	assign idle = state_q == S_IDLE;

endmodule

>>> rtl/quadtree_bfs_tile_walker_core.sv
// Breadth-first quadtree tile walker. A start word presents the root tile, or an overflow
// status if the queue limit is zero; each verdict word prunes the presented tile, queues
// its four children one level deeper or stops the walk, after which the oldest queued
// tile is presented, or a done, overflow or depth-exceeded status. The block works on one
// request word at a time; a result waiting in the output register does not stop the next
// request being taken, but that request's result waits until the earlier one is taken.
// The single-port queue memory takes one child write per cycle and then one registered
// read. If queue_limit was lowered below the head position during a walk, the next
// verdict first reduces the head position through the serial remainder unit.
// depends on qbt_pkg, qbt_if, qbt_rem, qbt_datapath, qbt_ctrl
`timescale 1ns / 1ps

module quadtree_bfs_tile_walker_core #(
	parameter int QUEUE_DEPTH = qbt_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_LEVEL   = qbt_pkg::MAX_LEVEL_DEF
) (
	input logic      clk,
	input logic      arst_n,
	qbt_req_if.sink  req,
	qbt_rsp_if.source rsp,
	qbt_cfg_if.sink  cfg
);
	import qbt_pkg::*;

	qbt_cmd_t cmd;
	qbt_sts_t sts;
	logic     idle;
	logic     req_fire;

	assign req.ready = idle;
	assign req_fire  = req.valid && idle;
	assign cfg.ready = 1'b1;

	qbt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_fire(req_fire),
		.opcode  (req.opcode),
		.verdict (req.verdict),
		.sts     (sts),
		.cmd     (cmd),
		.idle    (idle)
	);

	qbt_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_LEVEL  (MAX_LEVEL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_status(rsp.status),
		.out_level (rsp.node_level),
		.out_x     (rsp.node_x),
		.out_y     (rsp.node_y)
	);

endmodule

>>> rtl/qbt_checker.sv
// qbt_checker: port-level checks of the tile walker, bound to the top level
// depends on qbt_pkg and quadtree_bfs_tile_walker_core
`timescale 1ns / 1ps

module qbt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [qbt_pkg::STS_W-1:0]     rsp_status,
	input logic [qbt_pkg::LVL_OUT_W-1:0] rsp_level,
	input logic [qbt_pkg::CRD_OUT_W-1:0] rsp_x,
	input logic [qbt_pkg::CRD_OUT_W-1:0] rsp_y
);
	import qbt_pkg::*;

	// result word stays offered until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	// status words carry no tile
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STS_NODE |-> rsp_level == '0 && rsp_x == '0 && rsp_y == '0)
		else $error("status word with nonzero tile fields");

	// one request word in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous word in work");

	// no result during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("result valid during reset");

endmodule

bind quadtree_bfs_tile_walker_core qbt_checker u_qbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_status(rsp.status),
	.rsp_level (rsp.node_level),
	.rsp_x     (rsp.node_x),
	.rsp_y     (rsp.node_y)
);
